// ===== rtl/core/ampr_pkg.sv =====
// ----------------------------------------------------------------------------
// ampr_pkg
// Shared types and constants for the box penetration resolve unit.
// ----------------------------------------------------------------------------
package ampr_pkg;

    // Width and reset value of the push margin register.
    localparam int          MARGIN_WIDTH = 16;
    localparam logic [15:0] MARGIN_RESET = 16'd1;

    // Push axis codes as they appear on the result port.
    typedef enum logic [1:0] {
        AXIS_NONE = 2'd0,
        AXIS_X    = 2'd1,
        AXIS_Y    = 2'd2,
        AXIS_Z    = 2'd3
    } t_axis;

    // Per-axis status handed from an axis slice to the selection logic.
    typedef struct packed {
        logic hit;    // center distance within the half-extent sum
        logic d_neg;  // target center lies below the character center
    } t_axis_flags;

endpackage

// ===== rtl/core/ampr_axis.sv =====
// ----------------------------------------------------------------------------
// ampr_axis
// One axis slice: center distance, half-extent sum, overlap test and
// penetration depth.
// ----------------------------------------------------------------------------
module ampr_axis
    import ampr_pkg::*;
#(
    parameter int CW = 32
) (
    input  logic signed [CW-1:0] i_char_center,
    input  logic        [CW-2:0] i_char_half,
    input  logic signed [CW-1:0] i_target_center,
    input  logic        [CW-2:0] i_target_half,
    output logic signed [CW:0]   o_dist,
    output logic        [CW-1:0] o_sum,
    output logic signed [CW+1:0] o_pen,
    output t_axis_flags          o_flags
);

    logic [CW:0] abs_dist;

    // Signed distance from the character to the target and the half sum.
    assign o_dist = $signed({i_target_center[CW-1], i_target_center})
                  - $signed({i_char_center[CW-1], i_char_center});
    assign o_sum  = {1'b0, i_char_half} + {1'b0, i_target_half};

    // Magnitude of the distance; it never reaches the negative limit.
    assign abs_dist = o_dist[CW] ? (CW+1)'(-o_dist) : (CW+1)'(o_dist);

    // Touching counts as overlap.
    assign o_flags.hit   = (abs_dist <= {1'b0, o_sum});
    assign o_flags.d_neg = o_dist[CW];

    // Penetration depth, negative when the boxes are apart.
    assign o_pen = $signed({2'b00, o_sum}) - $signed({1'b0, abs_dist});

endmodule

// ===== rtl/core/ampr_select.sv =====
// ----------------------------------------------------------------------------
// ampr_select
// Picks the axis of least penetration and forms the saturated push move.
// ----------------------------------------------------------------------------
module ampr_select
    import ampr_pkg::*;
#(
    parameter int CW = 32
) (
    input  logic signed [CW:0]           i_dist   [3],
    input  logic        [CW-1:0]         i_sum    [3],
    input  logic signed [CW+1:0]         i_pen    [3],
    input  t_axis_flags                  i_flags  [3],
    input  logic [MARGIN_WIDTH-1:0]      i_margin,
    output logic                         o_overlap,
    output t_axis                        o_axis,
    output logic signed [CW-1:0]         o_move   [3],
    output logic                         o_landed
);

    localparam logic signed [CW+1:0] SAT_HI = (CW+2)'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic signed [CW+1:0] SAT_LO = -SAT_HI - (CW+2)'(1);

    logic                  hit;
    logic                  sel_d_neg;
    logic signed [CW:0]    sel_dist;
    logic        [CW:0]    sel_span;
    logic signed [CW+1:0]  dist_ext;
    logic signed [CW+1:0]  span_ext;
    logic signed [CW+1:0]  move_raw;
    logic signed [CW-1:0]  move_sat;
    logic [1:0]            idx;

    assign hit = i_flags[0].hit & i_flags[1].hit & i_flags[2].hit;

    // Strictly smallest penetration wins; a tie moves nothing.
    always_comb begin
        o_axis = AXIS_NONE;
        idx    = 2'd0;
        if (hit) begin
            if (i_pen[0] < i_pen[1] && i_pen[0] < i_pen[2]) begin
                o_axis = AXIS_X;
                idx    = 2'd0;
            end else if (i_pen[1] < i_pen[0] && i_pen[1] < i_pen[2]) begin
                o_axis = AXIS_Y;
                idx    = 2'd1;
            end else if (i_pen[2] < i_pen[0] && i_pen[2] < i_pen[1]) begin
                o_axis = AXIS_Z;
                idx    = 2'd2;
            end
        end
    end

    // Operands of the chosen axis; X and Z get the extra margin.
    always_comb begin
        case (idx)
            2'd1: begin
                sel_dist  = i_dist[1];
                sel_d_neg = i_flags[1].d_neg;
                sel_span  = {1'b0, i_sum[1]};
            end
            2'd2: begin
                sel_dist  = i_dist[2];
                sel_d_neg = i_flags[2].d_neg;
                sel_span  = {1'b0, i_sum[2]} + (CW+1)'(i_margin);
            end
            default: begin
                sel_dist  = i_dist[0];
                sel_d_neg = i_flags[0].d_neg;
                sel_span  = {1'b0, i_sum[0]} + (CW+1)'(i_margin);
            end
        endcase
    end

    // Push away from the target along the chosen axis.
    assign dist_ext = {sel_dist[CW], sel_dist};
    assign span_ext = $signed({1'b0, sel_span});
    assign move_raw = sel_d_neg ? (span_ext + dist_ext) : (dist_ext - span_ext);

    // Saturate to the output coordinate range.
    always_comb begin
        if (move_raw > SAT_HI) begin
            move_sat = SAT_HI[CW-1:0];
        end else if (move_raw < SAT_LO) begin
            move_sat = SAT_LO[CW-1:0];
        end else begin
            move_sat = move_raw[CW-1:0];
        end
    end

    // Only the chosen axis carries a move.
    assign o_move[0] = (o_axis == AXIS_X) ? move_sat : '0;
    assign o_move[1] = (o_axis == AXIS_Y) ? move_sat : '0;
    assign o_move[2] = (o_axis == AXIS_Z) ? move_sat : '0;

    assign o_overlap = hit;
    assign o_landed  = (o_axis == AXIS_Y) & sel_d_neg;

endmodule

// ===== rtl/core/aabb_min_penetration_resolve_unit.sv =====
// ----------------------------------------------------------------------------
// aabb_min_penetration_resolve_unit
// Box overlap test and minimum translation push for a character box.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. busy is
// always low, so one request can be issued in every cycle. Each request
// holds a character box and a target box as centers and half-extents.
// The request is captured in an input register at the edge that takes it,
// resolved in one pass of logic and loaded into the result register at the
// next edge. o_done is then high for exactly one cycle. The result path is
// a fixed two-stage pipeline, so the receiver cannot stall it and nothing
// is buffered beyond those two stages.
// The push margin register is written over its own channel (i_cfg_valid,
// o_cfg_ready, always ready) and should only change while no request is in
// flight. Reset clears the pipeline valid flags and sets the margin to one.
// ----------------------------------------------------------------------------
module aabb_min_penetration_resolve_unit
    import ampr_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_char_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_char_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_char_center_z,
    input  logic        [COORD_WIDTH-2:0] i_char_half_x,
    input  logic        [COORD_WIDTH-2:0] i_char_half_y,
    input  logic        [COORD_WIDTH-2:0] i_char_half_z,
    input  logic signed [COORD_WIDTH-1:0] i_target_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_target_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_target_center_z,
    input  logic        [COORD_WIDTH-2:0] i_target_half_x,
    input  logic        [COORD_WIDTH-2:0] i_target_half_y,
    input  logic        [COORD_WIDTH-2:0] i_target_half_z,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [MARGIN_WIDTH-1:0]       i_cfg_data,
    output logic                          o_done,
    output logic                          o_overlap,
    output logic [1:0]                    o_push_axis,
    output logic signed [COORD_WIDTH-1:0] o_move_x,
    output logic signed [COORD_WIDTH-1:0] o_move_y,
    output logic signed [COORD_WIDTH-1:0] o_move_z,
    output logic                          o_landed
);

    localparam int CW = COORD_WIDTH;

    logic [MARGIN_WIDTH-1:0] r_margin;
    logic                    r_in_vld;
    logic signed [CW-1:0]    r_cc [3];
    logic        [CW-2:0]    r_ch [3];
    logic signed [CW-1:0]    r_tc [3];
    logic        [CW-2:0]    r_th [3];

    logic signed [CW:0]      axis_dist [3];
    logic        [CW-1:0]    sum   [3];
    logic signed [CW+1:0]    pen   [3];
    t_axis_flags             flags [3];
    logic                    n_overlap;
    t_axis                   n_axis;
    logic signed [CW-1:0]    n_move [3];
    logic                    n_landed;

    logic                    r_done;
    logic                    r_overlap;
    t_axis                   r_axis;
    logic signed [CW-1:0]    r_move [3];
    logic                    r_landed;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Push margin register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RESET;
        end else if (i_cfg_valid) begin
            r_margin <= i_cfg_data;
        end
    end

    // Input register and its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cc[0] <= i_char_center_x;
            r_cc[1] <= i_char_center_y;
            r_cc[2] <= i_char_center_z;
            r_ch[0] <= i_char_half_x;
            r_ch[1] <= i_char_half_y;
            r_ch[2] <= i_char_half_z;
            r_tc[0] <= i_target_center_x;
            r_tc[1] <= i_target_center_y;
            r_tc[2] <= i_target_center_z;
            r_th[0] <= i_target_half_x;
            r_th[1] <= i_target_half_y;
            r_th[2] <= i_target_half_z;
        end
    end

    // One slice per axis.
    for (genvar k = 0; k < 3; k++) begin : g_axis
        ampr_axis #(
            .CW (CW)
        ) u_axis (
            .i_char_center   (r_cc[k]),
            .i_char_half     (r_ch[k]),
            .i_target_center (r_tc[k]),
            .i_target_half   (r_th[k]),
            .o_dist          (axis_dist[k]),
            .o_sum           (sum[k]),
            .o_pen           (pen[k]),
            .o_flags         (flags[k])
        );
    end

    // Axis choice and push move.
    ampr_select #(
        .CW (CW)
    ) u_select (
        .i_dist    (axis_dist),
        .i_sum     (sum),
        .i_pen     (pen),
        .i_flags   (flags),
        .i_margin  (r_margin),
        .o_overlap (n_overlap),
        .o_axis    (n_axis),
        .o_move    (n_move),
        .o_landed  (n_landed)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_overlap <= n_overlap;
            r_axis    <= n_axis;
            r_move    <= n_move;
            r_landed  <= n_landed;
        end
    end

    assign o_done      = r_done;
    assign o_overlap   = r_overlap;
    assign o_push_axis = r_axis;
    assign o_move_x    = r_move[0];
    assign o_move_y    = r_move[1];
    assign o_move_z    = r_move[2];
    assign o_landed    = r_landed;

endmodule

// ===== tb/tb_aabb_min_penetration_resolve_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aabb_min_penetration_resolve_unit
// Self-checking bench for the box penetration resolve unit. Requests are
// queued by a stimulus process, issued by a clocked driver with random gaps
// and checked by a clocked monitor against a local overlap and push
// predictor. The push margin is changed between drained phases, including
// its extremes.
// ----------------------------------------------------------------------------
module tb_aabb_min_penetration_resolve_unit;
    import ampr_pkg::*;

    localparam int     CW            = 32;
    localparam longint ONE           = 65536;
    localparam longint CMAX          = 64'sd2147483647;
    localparam longint CMIN          = -64'sd2147483648;
    localparam longint HMAX          = 64'sd2147483647;
    localparam int     IDLE_PERCENT  = 35;
    localparam int     SETTLE_CYCLES = 6;
    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     PRINT_CAP     = 40;

    // One request: both boxes, indexed by axis (0 = X, 1 = Y, 2 = Z).
    typedef struct packed {
        logic [2:0][CW-1:0] char_ctr;
        logic [2:0][CW-2:0] char_half;
        logic [2:0][CW-1:0] tgt_ctr;
        logic [2:0][CW-2:0] tgt_half;
    } t_box_pair;

    // One resolved push as it should leave the unit.
    typedef struct packed {
        logic               overlap;
        t_axis              axis;
        logic [2:0][CW-1:0] move;
        logic               landed;
    } t_push_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [MARGIN_WIDTH-1:0]       i_cfg_data = '0;
    logic                          o_done;
    logic                          o_overlap;
    logic [1:0]                    o_push_axis;
    logic signed [CW-1:0]          o_move_x;
    logic signed [CW-1:0]          o_move_y;
    logic signed [CW-1:0]          o_move_z;
    logic                          o_landed;

    t_box_pair    issued_pair = '0;
    t_box_pair    pending_pairs[$];
    t_push_result expected_pushes[$];
    logic [15:0]  margin_setting = MARGIN_RESET;
    logic         no_idle = 1'b0;
    int           error_count = 0;
    int           cycle_count = 0;
    int           result_count = 0;
    int           overlap_count = 0;
    int           tie_count = 0;
    int           landed_count = 0;
    int           saturated_count = 0;
    int           axis_count[4] = '{0, 0, 0, 0};

    aabb_min_penetration_resolve_unit #(
        .COORD_WIDTH(CW)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_char_center_x   (issued_pair.char_ctr[0]),
        .i_char_center_y   (issued_pair.char_ctr[1]),
        .i_char_center_z   (issued_pair.char_ctr[2]),
        .i_char_half_x     (issued_pair.char_half[0]),
        .i_char_half_y     (issued_pair.char_half[1]),
        .i_char_half_z     (issued_pair.char_half[2]),
        .i_target_center_x (issued_pair.tgt_ctr[0]),
        .i_target_center_y (issued_pair.tgt_ctr[1]),
        .i_target_center_z (issued_pair.tgt_ctr[2]),
        .i_target_half_x   (issued_pair.tgt_half[0]),
        .i_target_half_y   (issued_pair.tgt_half[1]),
        .i_target_half_z   (issued_pair.tgt_half[2]),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_done            (o_done),
        .o_overlap         (o_overlap),
        .o_push_axis       (o_push_axis),
        .o_move_x          (o_move_x),
        .o_move_y          (o_move_y),
        .o_move_z          (o_move_z),
        .o_landed          (o_landed)
    );

    // Clock: 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Push predictor
    // ------------------------------------------------------------------

    // Move along one axis: a target on the low side pushes the character up.
    function automatic longint shove(longint delta, longint reach);
        return (delta < 0) ? reach + delta : delta - reach;
    endfunction

    function automatic logic [CW-1:0] clamp_coord(longint v);
        if (v > CMAX) return 32'h7FFF_FFFF;
        if (v < CMIN) return 32'h8000_0000;
        return v[CW-1:0];
    endfunction

    function automatic t_push_result resolve_push(t_box_pair bp, logic [15:0] margin);
        longint       delta[3];
        longint       reach[3];
        longint       depth[3];
        longint       mag;
        longint       extra;
        logic         contact;
        t_push_result r;
        contact = 1'b1;
        extra = longint'(margin);
        r = '0;
        r.axis = AXIS_NONE;
        for (int a = 0; a < 3; a++) begin
            delta[a] = longint'($signed(bp.tgt_ctr[a])) - longint'($signed(bp.char_ctr[a]));
            reach[a] = longint'(bp.char_half[a]) + longint'(bp.tgt_half[a]);
            mag      = (delta[a] < 0) ? -delta[a] : delta[a];
            depth[a] = reach[a] - mag;
            if (mag > reach[a]) contact = 1'b0;
        end
        if (!contact) return r;
        r.overlap = 1'b1;
        // Strictly least penetration wins; any tie leaves the character alone.
        if (depth[0] < depth[1] && depth[0] < depth[2]) begin
            r.axis    = AXIS_X;
            r.move[0] = clamp_coord(shove(delta[0], reach[0] + extra));
        end else if (depth[1] < depth[0] && depth[1] < depth[2]) begin
            r.axis    = AXIS_Y;
            r.move[1] = clamp_coord(shove(delta[1], reach[1]));
            r.landed  = delta[1] < 0;
        end else if (depth[2] < depth[0] && depth[2] < depth[1]) begin
            r.axis    = AXIS_Z;
            r.move[2] = clamp_coord(shove(delta[2], reach[2] + extra));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------

    task automatic queue_pair(input longint cx, cy, cz, hx, hy, hz,
                              input longint tx, ty, tz, gx, gy, gz);
        t_box_pair bp;
        bp.char_ctr[0] = cx[CW-1:0];
        bp.char_ctr[1] = cy[CW-1:0];
        bp.char_ctr[2] = cz[CW-1:0];
        bp.char_half[0] = hx[CW-2:0];
        bp.char_half[1] = hy[CW-2:0];
        bp.char_half[2] = hz[CW-2:0];
        bp.tgt_ctr[0] = tx[CW-1:0];
        bp.tgt_ctr[1] = ty[CW-1:0];
        bp.tgt_ctr[2] = tz[CW-1:0];
        bp.tgt_half[0] = gx[CW-2:0];
        bp.tgt_half[1] = gy[CW-2:0];
        bp.tgt_half[2] = gz[CW-2:0];
        pending_pairs.push_back(bp);
    endtask

    // Hand-picked cases: misses, touching, every push direction, ties and
    // saturation at the coordinate limits.
    task automatic queue_directed_pairs();
        queue_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_pair(0, 0, 0, ONE, ONE, ONE, 3*ONE, 0, 0, ONE, ONE, ONE);
        queue_pair(0, 0, 0, ONE, ONE, ONE, 0, 0, 2*ONE+1, ONE, ONE, ONE);
        queue_pair(0, 0, 0, ONE, ONE, ONE, 2*ONE, 0, 0, ONE, ONE, ONE);
        queue_pair(0, 0, 0, ONE, ONE, ONE, -ONE, 0, 0, ONE, ONE, ONE);
        queue_pair(0, 0, 0, ONE, ONE, ONE, 0, -ONE, 0, ONE, ONE, ONE);
        queue_pair(0, 0, 0, ONE, ONE, ONE, 0, ONE, 0, ONE, ONE, ONE);
        // Equal Y centers: the push goes down and the character does not land.
        queue_pair(5, 7, 9, 4*ONE, ONE, 4*ONE, 5, 7, 9, 4*ONE, ONE, 4*ONE);
        queue_pair(0, 0, 0, ONE, ONE, ONE, 0, 0, ONE, ONE, ONE, ONE);
        queue_pair(0, 0, 0, ONE, ONE, ONE, 0, 0, -ONE, ONE, ONE, ONE);
        queue_pair(0, 0, 0, ONE, ONE, ONE, ONE, ONE, 0, ONE, ONE, ONE);
        queue_pair(0, 0, 0, ONE, ONE, ONE, ONE, 0, -ONE, ONE, ONE, ONE);
        queue_pair(CMIN, CMIN, CMIN, HMAX, HMAX, HMAX, CMAX, CMAX, CMAX, HMAX, HMAX, HMAX);
        queue_pair(CMAX, CMAX, CMAX, HMAX, HMAX, HMAX, CMIN, CMIN, CMIN, HMAX, HMAX, HMAX);
        queue_pair(CMIN+1, 0, 0, HMAX, HMAX, HMAX, CMAX, 0, 0, HMAX, HMAX, HMAX);
        // Widest boxes: the moves run past the coordinate range.
        queue_pair(0, 0, 0, HMAX, HMAX, HMAX, -1, 0, 0, HMAX, HMAX, HMAX);
        queue_pair(0, 0, 0, HMAX, HMAX, HMAX, 1, 0, 0, HMAX, HMAX, HMAX);
        queue_pair(0, 0, 0, HMAX, HMAX, HMAX, 0, -1, 0, HMAX, HMAX, HMAX);
        queue_pair(0, 0, 0, HMAX, HMAX, HMAX, 0, 1, 0, HMAX, HMAX, HMAX);
        queue_pair(0, 0, 0, HMAX, HMAX, HMAX, 0, 0, -1, HMAX, HMAX, HMAX);
        queue_pair(-1, -1, -1, HMAX, HMAX, HMAX, -1, -1, 0, HMAX, HMAX, HMAX);
    endtask

    // Half-extent at a random scale, from a single LSB up to the full width.
    function automatic logic [CW-2:0] random_half();
        logic [31:0] r;
        r = $urandom >> $urandom_range(31, 0);
        return r[CW-2:0];
    endfunction

    // Mostly overlapping pairs with random content; some touch exactly or
    // just miss, some force a tie, and the rest are unrelated boxes.
    task automatic queue_random_pairs(input int count);
        t_box_pair   bp;
        longint      offset[3];
        longint      reach;
        logic [63:0] sum;
        int          mode;
        int          edge_axis;
        int          a;
        int          b;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(99);
            edge_axis = $urandom_range(2);
            for (int k = 0; k < 3; k++) begin
                bp.char_ctr[k]  = $urandom;
                bp.tgt_ctr[k]   = $urandom;
                bp.char_half[k] = random_half();
                bp.tgt_half[k]  = random_half();
                reach = longint'(bp.char_half[k]) + longint'(bp.tgt_half[k]);
                offset[k] = longint'({$urandom, $urandom} >> 2) % (reach + 1);
                if (mode >= 15 && mode < 27 && k == edge_axis)
                    offset[k] = reach + longint'($urandom_range(1));
                if ($urandom_range(1)) offset[k] = -offset[k];
            end
            if (mode >= 27 && mode < 42) begin
                a = $urandom_range(2);
                b = (a + 1 + $urandom_range(1)) % 3;
                bp.char_half[b] = bp.char_half[a];
                bp.tgt_half[b]  = bp.tgt_half[a];
                offset[b] = $urandom_range(1) ? offset[a] : -offset[a];
            end
            if (mode >= 15) begin
                for (int k = 0; k < 3; k++) begin
                    sum = longint'($signed(bp.char_ctr[k])) + offset[k];
                    bp.tgt_ctr[k] = sum[CW-1:0];
                end
            end
            pending_pairs.push_back(bp);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: issues queued requests, idling at random unless told not to.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic      next_start;
        t_box_pair next_pair;
        next_start = start;
        next_pair  = issued_pair;
        if (!i_rst_n) begin
            next_start = 1'b0;
        end else begin
            if (start && !busy) begin
                expected_pushes.push_back(resolve_push(issued_pair, margin_setting));
                next_start = 1'b0;
            end
            if (!next_start && pending_pairs.size() != 0 &&
                (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
                next_pair  = pending_pairs.pop_front();
                next_start = 1'b1;
            end
        end
        start       <= next_start;
        issued_pair <= next_pair;
    end

    // ------------------------------------------------------------------
    // Monitor: every done strobe is matched against the oldest request.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < PRINT_CAP)
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_push_result want;
        if (i_rst_n && o_done) begin
            if (expected_pushes.size() == 0) begin
                report_mismatch("result with no request outstanding", 1, 0);
            end else begin
                want = expected_pushes.pop_front();
                result_count++;
                if (o_overlap !== want.overlap)
                    report_mismatch("overlap", o_overlap, want.overlap);
                if (o_push_axis !== want.axis)
                    report_mismatch("push_axis", o_push_axis, want.axis);
                if (o_move_x !== want.move[0])
                    report_mismatch("move_x", o_move_x, $signed(want.move[0]));
                if (o_move_y !== want.move[1])
                    report_mismatch("move_y", o_move_y, $signed(want.move[1]));
                if (o_move_z !== want.move[2])
                    report_mismatch("move_z", o_move_z, $signed(want.move[2]));
                if (o_landed !== want.landed)
                    report_mismatch("landed", o_landed, want.landed);
                // Tally what the run actually exercised.
                if (want.overlap) overlap_count++;
                if (want.overlap && want.axis == AXIS_NONE) tie_count++;
                axis_count[want.axis]++;
                if (want.landed) landed_count++;
                for (int k = 0; k < 3; k++)
                    if (want.move[k] == 32'h7FFF_FFFF || want.move[k] == 32'h8000_0000)
                        saturated_count++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Phase control
    // ------------------------------------------------------------------

    // Wait until every queued request has been issued and answered.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_pairs.size() != 0 || start || expected_pushes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Called at a rising edge with the unit idle.
    task automatic write_margin(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid    <= 1'b0;
        margin_setting = value;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases under the reset margin and both extremes.
        queue_directed_pairs();
        wait_drained();
        write_margin(16'd0);
        queue_directed_pairs();
        wait_drained();
        write_margin(16'hFFFF);
        queue_directed_pairs();
        wait_drained();

        // Random traffic: a back-to-back burst first, then normal gaps.
        write_margin(16'($urandom));
        no_idle = 1'b1;
        queue_random_pairs(300);
        wait_drained();
        no_idle = 1'b0;
        queue_random_pairs(300);
        wait_drained();
        write_margin(16'($urandom_range(15)));
        queue_random_pairs(600);
        wait_drained();
        write_margin(MARGIN_RESET);
        queue_random_pairs(600);
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Checked %0d requests: %0d overlapping, %0d ties, X/Y/Z pushes %0d/%0d/%0d.",
                 result_count, overlap_count, tie_count,
                 axis_count[AXIS_X], axis_count[AXIS_Y], axis_count[AXIS_Z]);
        $display("Landings: %0d, saturated moves: %0d, margins 1, 0, 65535 and random.",
                 landed_count, saturated_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
